@@ hdl/idxal_pkg.sv @@
// Shared types and constants for the indexed array list block.
// Used by idxal_ctrl, idxal_datapath and indexed_array_list; no dependencies.
`timescale 1ns / 1ps

package idxal_pkg;

    // List storage geometry
    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Request operation codes
    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_APPEND = 3'd1,
        OP_READ   = 3'd2,
        OP_DELETE = 3'd3,
        OP_EDIT   = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_OVERFLOW  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch the request fields
        logic execute;   // apply the latched request and register the result
    } ctrl_cmd_t;

endpackage

@@ hdl/idxal_ctrl.sv @@
// Controller state machine for the indexed array list.
// Depends on idxal_pkg; drives the command struct into idxal_datapath.
`timescale 1ns / 1ps

module idxal_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 cfg_ready,
    output logic                 done,
    output idxal_pkg::ctrl_cmd_t cmd
);

    idxal_pkg::state_t state_reg;
    idxal_pkg::state_t state_next;
    logic              done_reg;
    logic              done_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= idxal_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state: each accepted request moves from ST_IDLE to ST_EXEC and back
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            idxal_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = idxal_pkg::ST_EXEC;
            end
            idxal_pkg::ST_EXEC:
            begin
                state_next = idxal_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = idxal_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        busy        = 1'b0;
        cfg_ready   = 1'b0;
        unique case (state_reg)
            idxal_pkg::ST_IDLE:
            begin
                cmd.capture = start;
                cfg_ready   = 1'b1;
            end
            idxal_pkg::ST_EXEC:
            begin
                cmd.execute = 1'b1;
                busy        = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // Strobe the result in the cycle after execute
    assign done_next = cmd.execute;
    assign done      = done_reg;

endmodule

@@ hdl/idxal_datapath.sv @@
// Datapath for the indexed array list: entry array, count, capacity, result registers.
// Depends on idxal_pkg; controlled by the command struct from idxal_ctrl.
`timescale 1ns / 1ps

module idxal_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  idxal_pkg::ctrl_cmd_t                 cmd,
    input  logic [2:0]                           operation,
    input  logic [idxal_pkg::IDX_W-1:0]          index,
    input  logic [idxal_pkg::DATA_WIDTH-1:0]     data,
    input  logic                                 cfg_we,
    input  logic [idxal_pkg::CNT_W-1:0]          cfg_data,
    output logic [idxal_pkg::DATA_WIDTH-1:0]     read_data,
    output logic [1:0]                           status,
    output logic [idxal_pkg::CNT_W-1:0]          entry_count,
    output logic                                 is_full,
    output logic                                 is_empty
);

    localparam int DEPTH = idxal_pkg::DEPTH;
    localparam int DW    = idxal_pkg::DATA_WIDTH;
    localparam int IW    = idxal_pkg::IDX_W;
    localparam int CW    = idxal_pkg::CNT_W;

    // Latched request
    logic [2:0]    op_reg;
    logic [IW-1:0] pos_reg;
    logic [DW-1:0] data_reg;

    // List state
    logic [DW-1:0] store_reg  [DEPTH];
    logic [DW-1:0] store_next [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] cap_reg;
    logic [CW-1:0] cap_eff;

    // Result registers
    logic [DW-1:0] rdata_reg;
    logic [DW-1:0] rdata_next;
    logic [1:0]    status_reg;
    logic [1:0]    status_next;
    logic          full_reg;
    logic          empty_reg;

    logic [CW-1:0] pos_ext;
    logic          pos_in_list;
    logic          pos_le_count;
    logic          list_full;

    // Hold the request fields on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= operation;
            pos_reg  <= index;
            data_reg <= data;
        end
    end

    // Clamp capacity to the range one to DEPTH
    always_comb
    begin
        if (cap_reg == '0)
            cap_eff = CW'(1);
        else if (cap_reg > CW'(DEPTH))
            cap_eff = CW'(DEPTH);
        else
            cap_eff = cap_reg;
    end

    assign pos_ext      = CW'(pos_reg);
    assign pos_in_list  = (pos_ext < count_reg);
    assign pos_le_count = (pos_ext <= count_reg);
    assign list_full    = (count_reg >= cap_eff);

    // Decode the operation and build the next array contents
    always_comb
    begin
        store_next  = store_reg;
        count_next  = count_reg;
        rdata_next  = '0;
        status_next = idxal_pkg::STAT_OK;
        case (op_reg)
            idxal_pkg::OP_INSERT:
            begin
                if (!pos_le_count)
                    status_next = idxal_pkg::STAT_BAD_INDEX;
                else if (list_full)
                    status_next = idxal_pkg::STAT_OVERFLOW;
                else
                begin
                    // Shift entries above the position up by one
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        if (IW'(i) > pos_reg)
                            store_next[i] = store_reg[i-1];
                    end
                    store_next[pos_reg] = data_reg;
                    count_next          = count_reg + CW'(1);
                end
            end
            idxal_pkg::OP_APPEND:
            begin
                if (list_full)
                    status_next = idxal_pkg::STAT_OVERFLOW;
                else
                begin
                    store_next[count_reg[IW-1:0]] = data_reg;
                    count_next                    = count_reg + CW'(1);
                end
            end
            idxal_pkg::OP_READ:
            begin
                if (!pos_in_list)
                    status_next = idxal_pkg::STAT_BAD_INDEX;
                else
                    rdata_next = store_reg[pos_reg];
            end
            idxal_pkg::OP_DELETE:
            begin
                if (!pos_in_list)
                    status_next = idxal_pkg::STAT_BAD_INDEX;
                else
                begin
                    // Shift entries above the position down by one
                    for (int i = 0; i < DEPTH - 1; i++)
                    begin
                        if (IW'(i) >= pos_reg)
                            store_next[i] = store_reg[i+1];
                    end
                    count_next = count_reg - CW'(1);
                end
            end
            idxal_pkg::OP_EDIT:
            begin
                if (!pos_in_list)
                    status_next = idxal_pkg::STAT_BAD_INDEX;
                else
                    store_next[pos_reg] = data_reg;
            end
            default:
            begin
                status_next = idxal_pkg::STAT_OK;
            end
        endcase
    end

    // Update the entry array
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
            store_reg <= store_next;
    end

    // Count and capacity; a capacity write empties the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            cap_reg   <= CW'(DEPTH);
        end
        else if (cfg_we)
        begin
            count_reg <= '0;
            cap_reg   <= cfg_data;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    // Register the result
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            rdata_reg  <= rdata_next;
            status_reg <= status_next;
            full_reg   <= (count_next == cap_eff);
            empty_reg  <= (count_next == '0);
        end
    end

    assign read_data   = rdata_reg;
    assign status      = status_reg;
    assign entry_count = count_reg;
    assign is_full     = full_reg;
    assign is_empty    = empty_reg;

endmodule

@@ hdl/indexed_array_list.sv @@
// Top level of the indexed array list: controller plus datapath.
// Depends on idxal_pkg, idxal_ctrl and idxal_datapath.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. The block then
// applies it in the execute state (busy high) to the 16-entry register array,
// where every entry shifts in parallel, and shows the result for exactly one
// cycle with done high; the receiver cannot stall it, so capture it then. A
// request passes through the execute state and then the result registers,
// and a new request may be started in the cycle its predecessor's result is
// shown. entry_count follows the list at all times and matches the result
// while done is high. Write capacity only while busy is low and no result is
// pending; a write empties the list.

module indexed_array_list
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [2:0]                            operation,
    input  logic [idxal_pkg::IDX_W-1:0]           index,
    input  logic [idxal_pkg::DATA_WIDTH-1:0]      data,
    output logic                                  done,
    output logic [idxal_pkg::DATA_WIDTH-1:0]      read_data,
    output logic [1:0]                            status,
    output logic [idxal_pkg::CNT_W-1:0]           entry_count,
    output logic                                  is_full,
    output logic                                  is_empty,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [idxal_pkg::CNT_W-1:0]           cfg_data
);

    idxal_pkg::ctrl_cmd_t cmd;
    logic                 cfg_we;

    assign cfg_we = cfg_valid & cfg_ready;

    // Controller
    idxal_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done),
        .cmd       (cmd)
    );

    // Datapath
    idxal_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (operation),
        .index       (index),
        .data        (data),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .read_data   (read_data),
        .status      (status),
        .entry_count (entry_count),
        .is_full     (is_full),
        .is_empty    (is_empty)
    );

`ifndef SYNTHESIS
    // Execute is always followed by the result strobe, with busy low again
    a_exec_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execute cycle not followed by result strobe");

    // A result strobe only follows an execute cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(busy))
        else $error("result strobe without execute");

    // Overflow is only reported when the list is full
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == idxal_pkg::STAT_OVERFLOW) |-> is_full)
        else $error("overflow reported on a list that is not full");

    // Count never exceeds the array depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count <= idxal_pkg::CNT_W'(idxal_pkg::DEPTH))
        else $error("entry count above depth");
`endif

endmodule
